### rtl/odsu_pkg.sv
// Package for the oscillator divider search unit.
// Holds field widths, search constants, the high-speed divider table and the
// request/response structs of the shared serial multiplier. No dependencies.
package odsu_pkg;

	localparam int CRYSTAL_W  = 43;
	localparam int TARGET_W   = 47;
	localparam int N1_CODE_W  = 7;
	localparam int HS_CODE_W  = 3;
	localparam int RFREQ_W    = 38;
	localparam int RFREQ_FRAC = 28;
	localparam int HZ_FRAC    = 16;
	localparam int LIM_SHIFT  = RFREQ_FRAC + HZ_FRAC;

	localparam int FD_W      = 58;
	localparam int NUM_W     = FD_W + RFREQ_FRAC;
	localparam int QUO_W     = RFREQ_W + 1;
	localparam int OSC_W     = RFREQ_W + CRYSTAL_W;
	localparam int DIV_CNT_W = 6;

	localparam int MUL_A_W   = NUM_W;
	localparam int MUL_B_W   = RFREQ_W;
	localparam int MUL_P_W   = 97;
	localparam int MUL_CNT_W = 6;

	localparam int HS_CNT   = 6;
	localparam int HS_IDX_W = 3;
	localparam int HS_VAL_W = 4;

	localparam int ERR_MAX_W = 30;
	localparam int LIM_P_W   = NUM_W - 1 - LIM_SHIFT;

	localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET = 43'd7489781760000;
	localparam logic [ERR_MAX_W-1:0] ERR_MAX_HZ    = 30'd1000000000;
	localparam logic [OSC_W-1:0] OSC_MIN = OSC_W'(64'd4850000000) << LIM_SHIFT;
	localparam logic [OSC_W-1:0] OSC_MAX = OSC_W'(64'd5670000000) << LIM_SHIFT;
	localparam logic [HS_IDX_W-1:0] HS_IDX_LAST = HS_IDX_W'(HS_CNT - 1);

	typedef struct packed {
		logic                 start;
		logic [MUL_A_W-1:0]   a;
		logic [MUL_B_W-1:0]   b;
		logic [MUL_CNT_W-1:0] nbits;
	} mul_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [MUL_P_W-1:0] prod;
	} mul_rsp_t;

	function automatic logic [HS_VAL_W-1:0] hs_value(input logic [HS_IDX_W-1:0] idx);
		logic [HS_VAL_W-1:0] v;
		case (idx)
			3'd0:    v = 4'd11;
			3'd1:    v = 4'd9;
			3'd2:    v = 4'd7;
			3'd3:    v = 4'd6;
			3'd4:    v = 4'd5;
			default: v = 4'd4;
		endcase
		return v;
	endfunction

endpackage

### rtl/odsu_cfg_if.sv
// Configuration write channel of the oscillator divider search unit.
// Depends on odsu_pkg.
interface odsu_cfg_if;
	import odsu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CRYSTAL_W-1:0] crystal_freq;
	modport source (output valid, output crystal_freq, input ready);
	modport sink (input valid, input crystal_freq, output ready);
endinterface

### rtl/odsu_in_if.sv
// Request channel carrying a target frequency.
// Depends on odsu_pkg.
interface odsu_in_if;
	import odsu_pkg::*;
	logic                valid;
	logic                ready;
	logic [TARGET_W-1:0] target_freq;
	modport source (output valid, output target_freq, input ready);
	modport sink (input valid, input target_freq, output ready);
endinterface

### rtl/odsu_out_if.sv
// Result channel carrying the chosen divider codes and multiplier.
// Depends on odsu_pkg.
interface odsu_out_if;
	import odsu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [N1_CODE_W-1:0] n1_code;
	logic [HS_CODE_W-1:0] hs_div_code;
	logic [RFREQ_W-1:0]   rfreq_word;
	modport source (output valid, output found, output n1_code, output hs_div_code,
		output rfreq_word, input ready);
	modport sink (input valid, input found, input n1_code, input hs_div_code,
		input rfreq_word, output ready);
endinterface

### rtl/oscillator_divider_search_unit.sv
// Oscillator divider search unit: top level with the search sequencer.
// Each divider pair is searched with 12-step and 38-step serial multiplies and the 39-step
// restoring divider; the unit serves one request at a time.
// The result register frees the input side while a result waits.
// Reset clears control state and sets crystal_freq to 114.285 MHz.
module oscillator_divider_search_unit #(
	parameter int N1_MAX = 128
) (
	input logic clk,
	input logic arst_n,
	odsu_cfg_if.sink   cfg,
	odsu_in_if.sink    target,
	odsu_out_if.source result
);
	import odsu_pkg::*;

	localparam int N1_W = $clog2(N1_MAX + 1);
	localparam int D_W  = HS_VAL_W + N1_W;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_FD    = 11'b00000000010,
		S_DIV   = 11'b00000000100,
		S_ROUND = 11'b00000001000,
		S_OSC   = 11'b00000010000,
		S_CHECK = 11'b00000100000,
		S_LIM   = 11'b00001000000,
		S_CMP1  = 11'b00010000000,
		S_CMP2  = 11'b00100000000,
		S_NEXT  = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic   wait_q;
	logic   have_q;

	logic [CRYSTAL_W-1:0] x_q;
	logic [TARGET_W-1:0]  f_q;
	logic [HS_IDX_W-1:0]  hs_idx_q;
	logic [N1_W-1:0]      n1_q;
	logic [NUM_W-1:0]     num_q;
	logic [QUO_W-1:0]     dbits_q;
	logic [QUO_W-1:0]     quo_q;
	logic [CRYSTAL_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [RFREQ_W-1:0]   rf_q;
	logic [OSC_W-1:0]     osc_q;
	logic [NUM_W-1:0]     err_q;
	logic [MUL_P_W-1:0]   prod_q;

	logic [NUM_W-1:0]    best_err_q;
	logic [D_W-1:0]      best_d_q;
	logic [N1_W-1:0]     best_n1_q;
	logic [HS_IDX_W-1:0] best_hs_q;
	logic [RFREQ_W-1:0]  best_rf_q;

	logic                 out_valid_q;
	logic                 out_found_q;
	logic [N1_CODE_W-1:0] out_n1_q;
	logic [HS_CODE_W-1:0] out_hs_q;
	logic [RFREQ_W-1:0]   out_rf_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	logic [D_W-1:0]       d_cur;
	logic [NUM_W-1:0]     num_new;
	logic                 div_ovf;
	logic [CRYSTAL_W:0]   div_t;
	logic                 div_ge;
	logic [CRYSTAL_W:0]   rem2;
	logic                 rnd_inc;
	logic [QUO_W:0]       quo_rnd;
	logic                 in_range;
	logic                 num_ge;
	logic [NUM_W-1:0]     err_cur;
	logic [NUM_W-1:0]     lim_cur;
	logic                 take;
	logic                 n1_last;
	logic [N1_W:0]        n1_next;
	logic                 out_load;

	assign d_cur   = D_W'(hs_value(hs_idx_q)) * D_W'(n1_q);
	assign num_new = {mul_rsp.prod[FD_W-1:0], {RFREQ_FRAC{1'b0}}};
	assign div_ovf = num_new[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(x_q);
	assign div_t   = {rem_q, dbits_q[QUO_W-1]};
	assign div_ge  = div_t >= {1'b0, x_q};
	assign rem2    = {rem_q, 1'b0};
	assign rnd_inc = (rem2 > {1'b0, x_q}) || ((rem2 == {1'b0, x_q}) && quo_q[0]);
	assign quo_rnd = {1'b0, quo_q} + (QUO_W+1)'(rnd_inc);
	assign in_range = (osc_q >= OSC_MIN) && (osc_q <= OSC_MAX);
	assign num_ge  = num_q >= NUM_W'(osc_q);
	assign err_cur = num_ge ? (num_q - NUM_W'(osc_q)) : (NUM_W'(osc_q) - num_q);
	assign lim_cur = {1'b0, mul_rsp.prod[LIM_P_W-1:0], {LIM_SHIFT{1'b0}}};
	assign n1_next = (N1_W+1)'(n1_q) + (N1_W+1)'(2);
	assign n1_last = n1_next > (N1_W+1)'(N1_MAX);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || result.ready);

	always_comb begin
		take = 1'b0;
		if (wait_q && mul_rsp.done) begin
			if (state_q == S_LIM) begin
				take = err_q < lim_cur;
			end else if (state_q == S_CMP2) begin
				take = prod_q < mul_rsp.prod;
			end
		end
	end

	always_comb begin
		mul_req = '0;
		unique case (state_q)
			S_FD: begin
				mul_req.a     = MUL_A_W'(f_q);
				mul_req.b     = MUL_B_W'(d_cur);
				mul_req.nbits = MUL_CNT_W'(D_W);
			end
			S_OSC: begin
				mul_req.a     = MUL_A_W'(x_q);
				mul_req.b     = rf_q;
				mul_req.nbits = MUL_CNT_W'(RFREQ_W);
			end
			S_LIM: begin
				mul_req.a     = MUL_A_W'(ERR_MAX_HZ);
				mul_req.b     = MUL_B_W'(d_cur);
				mul_req.nbits = MUL_CNT_W'(D_W);
			end
			S_CMP1: begin
				mul_req.a     = err_q;
				mul_req.b     = MUL_B_W'(best_d_q);
				mul_req.nbits = MUL_CNT_W'(D_W);
			end
			S_CMP2: begin
				mul_req.a     = best_err_q;
				mul_req.b     = MUL_B_W'(d_cur);
				mul_req.nbits = MUL_CNT_W'(D_W);
			end
			default: begin
				mul_req.a = '0;
			end
		endcase
		if ((state_q == S_FD) || (state_q == S_OSC) || (state_q == S_LIM) ||
			(state_q == S_CMP1) || (state_q == S_CMP2)) begin
			mul_req.start = !wait_q;
		end
	end

	odsu_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign cfg.ready    = 1'b1;
	assign target.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= CRYSTAL_RESET;
		end else if (cfg.valid) begin
			x_q <= cfg.crystal_freq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= 1'b0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
			hs_idx_q    <= '0;
			n1_q        <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (target.valid) begin
						hs_idx_q <= '0;
						n1_q     <= N1_W'(2);
						have_q   <= 1'b0;
						state_q  <= S_FD;
					end
				end
				S_FD: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mul_rsp.done) begin
						wait_q    <= 1'b0;
						div_cnt_q <= DIV_CNT_W'(QUO_W);
						state_q   <= div_ovf ? S_NEXT : S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(1)) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					state_q <= (quo_rnd[QUO_W:RFREQ_W] != '0) ? S_NEXT : S_OSC;
				end
				S_OSC: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mul_rsp.done) begin
						wait_q  <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!in_range) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= have_q ? S_CMP1 : S_LIM;
					end
				end
				S_LIM, S_CMP2: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mul_rsp.done) begin
						wait_q  <= 1'b0;
						state_q <= S_NEXT;
						if (take) begin
							have_q <= 1'b1;
						end
					end
				end
				S_CMP1: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (mul_rsp.done) begin
						wait_q  <= 1'b0;
						state_q <= S_CMP2;
					end
				end
				S_NEXT: begin
					if (n1_last) begin
						n1_q <= N1_W'(2);
						if (hs_idx_q == HS_IDX_LAST) begin
							state_q <= S_OUT;
						end else begin
							hs_idx_q <= hs_idx_q + HS_IDX_W'(1);
							state_q  <= S_FD;
						end
					end else begin
						n1_q    <= n1_next[N1_W-1:0];
						state_q <= S_FD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (target.valid && target.ready) begin
			f_q <= target.target_freq;
		end
		if ((state_q == S_FD) && wait_q && mul_rsp.done) begin
			num_q   <= num_new;
			rem_q   <= num_new[QUO_W+CRYSTAL_W-1:QUO_W];
			dbits_q <= num_new[QUO_W-1:0];
		end
		if (state_q == S_DIV) begin
			rem_q   <= div_ge ? CRYSTAL_W'(div_t - {1'b0, x_q}) : div_t[CRYSTAL_W-1:0];
			quo_q   <= {quo_q[QUO_W-2:0], div_ge};
			dbits_q <= {dbits_q[QUO_W-2:0], 1'b0};
		end
		if (state_q == S_ROUND) begin
			rf_q <= quo_rnd[RFREQ_W-1:0];
		end
		if ((state_q == S_OSC) && wait_q && mul_rsp.done) begin
			osc_q <= mul_rsp.prod[OSC_W-1:0];
		end
		if (state_q == S_CHECK) begin
			err_q <= err_cur;
		end
		if ((state_q == S_CMP1) && wait_q && mul_rsp.done) begin
			prod_q <= mul_rsp.prod;
		end
		if (take) begin
			best_err_q <= err_q;
			best_d_q   <= d_cur;
			best_n1_q  <= n1_q;
			best_hs_q  <= hs_idx_q;
			best_rf_q  <= rf_q;
		end
		if (out_load) begin
			out_found_q <= have_q;
			out_n1_q    <= have_q ? N1_CODE_W'(8'(best_n1_q) - 8'd1) : '0;
			out_hs_q    <= have_q ? HS_CODE_W'(hs_value(best_hs_q) - HS_VAL_W'(4)) : '0;
			out_rf_q    <= have_q ? best_rf_q : '0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.found       = out_found_q;
	assign result.n1_code     = out_n1_q;
	assign result.hs_div_code = out_hs_q;
	assign result.rfreq_word  = out_rf_q;

	a_mul_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy)
		else $error("multiplier started while busy");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(target.valid && target.ready) |=> !target.ready)
		else $error("request accepted without starting search");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.found) |->
		(result.n1_code == '0 && result.hs_div_code == '0 && result.rfreq_word == '0))
		else $error("codes not cleared when nothing fits");

	a_found_n1_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.found) |-> result.n1_code[0])
		else $error("output divider code from odd divider");

	a_take_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> have_q)
		else $error("candidate taken but not recorded");

endmodule

### rtl/odsu_serial_mul.sv
// Shared shift-and-add multiplier, one multiplier bit per cycle.
// Depends on odsu_pkg for widths and the request/response structs.
module odsu_serial_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  odsu_pkg::mul_req_t req,
	output odsu_pkg::mul_rsp_t rsp
);
	import odsu_pkg::*;

	logic [MUL_P_W-1:0]   acc_q;
	logic [MUL_P_W-1:0]   a_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start && !busy_q) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - MUL_CNT_W'(1);
			if (cnt_q == MUL_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			a_q   <= MUL_P_W'(req.a);
			b_q   <= req.b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[MUL_P_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

### sim/tb_oscillator_divider_search_unit.sv
// Testbench for the oscillator divider search unit: drives target frequencies
// under several crystal settings and checks every result against a predictor.
// Depends on odsu_pkg, the odsu channel interfaces and the RTL top level.
module tb_oscillator_divider_search_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import odsu_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic [CRYSTAL_W-1:0] XTAL_LOW  = 43'd6553600000000;
	localparam logic [CRYSTAL_W-1:0] XTAL_HIGH = 43'd8519680000000;

	typedef struct packed {
		logic                 found;
		logic [N1_CODE_W-1:0] n1_code;
		logic [HS_CODE_W-1:0] hs_div_code;
		logic [RFREQ_W-1:0]   rfreq_word;
	} divider_pick_t;

	function automatic divider_pick_t predict_search(logic [CRYSTAL_W-1:0] xtal,
			logic [TARGET_W-1:0] tgt);
		int hs_tab[6] = '{11, 9, 7, 6, 5, 4};
		logic [127:0] num, quo, rem, osc, err, lim, best_err, best_d, d;
		logic [127:0] osc_lo, osc_hi;
		bit have;
		divider_pick_t pick;
		pick = '0;
		have = 0;
		best_err = '0;
		best_d = 128'd1;
		osc_lo = 128'd4850000000 << LIM_SHIFT;
		osc_hi = 128'd5670000000 << LIM_SHIFT;
		if (xtal != 0) begin
			for (int h = 0; h < 6; h++) begin
				for (int n1 = 2; n1 <= 128; n1 += 2) begin
					d = 128'(hs_tab[h] * n1);
					num = (128'(tgt) * d) << RFREQ_FRAC;
					quo = num / 128'(xtal);
					rem = num % 128'(xtal);
					if ((rem << 1) > 128'(xtal) || ((rem << 1) == 128'(xtal) && quo[0]))
						quo = quo + 1;
					if ((quo >> RFREQ_W) != 0)
						continue;
					osc = quo * 128'(xtal);
					if (osc < osc_lo || osc > osc_hi)
						continue;
					err = (num >= osc) ? num - osc : osc - num;
					if (!have) begin
						lim = (128'd1000000000 * d) << LIM_SHIFT;
						if (err >= lim)
							continue;
					end else if (err * best_d >= best_err * d) begin
						continue;
					end
					have = 1;
					best_err = err;
					best_d = d;
					pick.found = 1'b1;
					pick.n1_code = N1_CODE_W'(n1 - 1);
					pick.hs_div_code = HS_CODE_W'(hs_tab[h] - 4);
					pick.rfreq_word = quo[RFREQ_W-1:0];
				end
			end
		end
		return pick;
	endfunction

	class search_scoreboard;
		logic [CRYSTAL_W-1:0] crystal = CRYSTAL_RESET;
		divider_pick_t expected_picks[$];
		int errors = 0;
		int checked = 0;

		function void note_target(logic [TARGET_W-1:0] tgt);
			expected_picks.push_back(predict_search(crystal, tgt));
		endfunction

		function void check_result(divider_pick_t got);
			divider_pick_t want;
			if (expected_picks.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = expected_picks.pop_front();
			checked++;
			if (got.found !== want.found) begin
				$display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
				errors++;
			end
			if (got.n1_code !== want.n1_code) begin
				$display("%0t: n1_code expected %0d actual %0d", $time, want.n1_code,
					got.n1_code);
				errors++;
			end
			if (got.hs_div_code !== want.hs_div_code) begin
				$display("%0t: hs_div_code expected %0d actual %0d", $time,
					want.hs_div_code, got.hs_div_code);
				errors++;
			end
			if (got.rfreq_word !== want.rfreq_word) begin
				$display("%0t: rfreq_word expected %0h actual %0h", $time,
					want.rfreq_word, got.rfreq_word);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit quiet = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int phases = 0;
	search_scoreboard sb = new();

	odsu_cfg_if cfg_ch();
	odsu_in_if  tgt_ch();
	odsu_out_if res_ch();

	oscillator_divider_search_unit #(.N1_MAX(128)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.target (tgt_ch),
		.result (res_ch)
	);

	always #5 clk = ~clk;

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.crystal_freq = '0;
		tgt_ch.valid = 1'b0;
		tgt_ch.target_freq = '0;
		res_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (tgt_ch.valid && tgt_ch.ready)
			sb.note_target(tgt_ch.target_freq);
		if (cfg_ch.valid && cfg_ch.ready)
			sb.crystal = cfg_ch.crystal_freq;
		if (res_ch.valid && res_ch.ready)
			sb.check_result('{res_ch.found, res_ch.n1_code, res_ch.hs_div_code,
				res_ch.rfreq_word});
	end

	always @(posedge clk) begin
		int next_stall;
		next_stall = stall_left;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				next_stall = quiet ? 0 : $urandom_range(0, 16);
			else if (stall_left > 0)
				next_stall = stall_left - 1;
		end
		stall_left <= next_stall;
		res_ch.ready <= arst_n && (next_stall == 0);
	end

	always @(posedge clk) begin
		if ((tgt_ch.valid && tgt_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_target(logic [TARGET_W-1:0] tgt);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			tgt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tgt_ch.valid <= 1'b1;
		tgt_ch.target_freq <= tgt;
		@(posedge clk);
		while (!tgt_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		tgt_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_picks.size() != 0) @(posedge clk);
	endtask

	task automatic write_crystal(logic [CRYSTAL_W-1:0] xtal);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.crystal_freq <= xtal;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		phases++;
	endtask

	function automatic logic [TARGET_W-1:0] random_target();
		logic [31:0] hz;
		if ($urandom_range(0, 9) < 8) begin
			hz = $urandom_range(3000000, 1500000000);
			return {hz[30:0], 16'($urandom)};
		end
		return TARGET_W'({$urandom, $urandom});
	endfunction

	task automatic random_run(int count, bit hold_mid);
		for (int i = 0; i < count; i++) begin
			if (hold_mid && i == count / 2)
				drain();
			send_target(random_target());
		end
	endtask

	initial begin
		logic [63:0] span;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		quiet = 1;
		send_target('0);
		send_target({TARGET_W{1'b1}});
		send_target(47'd98304000000000);
		send_target(47'd1);
		send_target(47'd10000000 << HZ_FRAC);
		send_target(47'd100000000 << HZ_FRAC);
		send_target(47'd156250000 << HZ_FRAC);
		send_target(47'd1417500000 << HZ_FRAC);
		send_target(47'd3444602 << HZ_FRAC);
		send_target(47'd3000000 << HZ_FRAC);
		send_target((47'd500000000 << HZ_FRAC) | 47'hFFFF);
		send_target(47'h2AAA_AAAA_AAAA);
		send_target(47'h5555_5555_5555);
		quiet = 0;
		random_run(15, 1);

		write_crystal(XTAL_HIGH);
		quiet = 1;
		random_run(15, 0);
		write_crystal(XTAL_LOW);
		quiet = 0;
		random_run(15, 0);
		write_crystal('0);
		send_target(47'd100000000 << HZ_FRAC);
		send_target('0);
		send_target(random_target());
		span = 64'(XTAL_HIGH - XTAL_LOW) + 1;
		write_crystal(XTAL_LOW + CRYSTAL_W'({$urandom, $urandom} % span));
		random_run(15, 0);
		write_crystal(XTAL_LOW + CRYSTAL_W'({$urandom, $urandom} % span));
		quiet = 1;
		random_run(10, 0);
		quiet = 0;
		write_crystal(CRYSTAL_RESET);
		random_run(8, 0);

		drain();
		repeat (200) @(posedge clk);
		$display("Checked %0d divider searches over %0d crystal settings", sb.checked,
			phases + 1);
		$display("Settings covered reset, both range ends, zero and random crystals");
		if (sb.errors == 0 && sb.expected_picks.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
